### rtl/core/image_pair_ncc_unit_macros.svh
// Assertion macros for the correlation block; only image_pair_ncc_unit.sv includes them.
`ifndef IMAGE_PAIR_NCC_UNIT_MACROS_SVH
`define IMAGE_PAIR_NCC_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPNCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPNCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ipncc_pkg.sv
package ipncc_pkg;

   localparam int PIXEL_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 21;

   // fixed field widths
   localparam int PIX_FIELD_W = 16;
   localparam int THR_W       = 15;
   localparam int NCC_W       = 16;

   localparam logic [THR_W-1:0] THR_RESET = 15'd16368;

   // result magnitude is 0..2^Q_FRAC
   localparam int Q_FRAC = 14;
   localparam int Q_W    = Q_FRAC + 1;
   localparam int QK_W   = 4;

   localparam logic signed [NCC_W-1:0] Q_ONE_S = 16'sd16384;

   // finish result handed from the sequencer to the output stage
   typedef struct packed {
      logic [Q_W-1:0] mag;
      logic           neg;
      logic           flat;
   } ncc_result_type;

   // width of the shared adder: squared variance product shifted by 2*Q_FRAC, plus margin
   function automatic int wide_width(input int pix_bits, input int cnt_bits);
      return 4 * (pix_bits + cnt_bits) + 2 * Q_FRAC + 2;
   endfunction

endpackage

### rtl/core/ipncc_accum.sv
module ipncc_accum
   import ipncc_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  beat_in,
   input  logic [PIXEL_BITS-1:0]                 pix_a,
   input  logic [PIXEL_BITS-1:0]                 pix_b,
   input  logic                                  last_in,
   input  logic                                  clear,
   output logic                                  stage_last,
   output logic [COUNT_BITS-1:0]                 count,
   output logic [PIXEL_BITS+COUNT_BITS-1:0]      sum_a,
   output logic [PIXEL_BITS+COUNT_BITS-1:0]      sum_b,
   output logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_aa,
   output logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_bb,
   output logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_ab
);

   localparam int PW2 = 2 * PIXEL_BITS;
   localparam int S1W = PIXEL_BITS + COUNT_BITS;
   localparam int S2W = 2 * PIXEL_BITS + COUNT_BITS;

   logic                  stage_valid_ff;
   logic                  stage_last_ff;
   logic [PIXEL_BITS-1:0] a_ff;
   logic [PIXEL_BITS-1:0] b_ff;
   logic [PW2-1:0]        prod_aa_ff;
   logic [PW2-1:0]        prod_bb_ff;
   logic [PW2-1:0]        prod_ab_ff;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [S1W-1:0]        sum_a_ff, sum_a_in;
   logic [S1W-1:0]        sum_b_ff, sum_b_in;
   logic [S2W-1:0]        sum_aa_ff, sum_aa_in;
   logic [S2W-1:0]        sum_bb_ff, sum_bb_in;
   logic [S2W-1:0]        sum_ab_ff, sum_ab_in;

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         stage_last_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= beat_in;
         stage_last_ff  <= beat_in & last_in;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (beat_in) begin
         a_ff       <= pix_a;
         b_ff       <= pix_b;
         prod_aa_ff <= {{PIXEL_BITS{1'b0}}, pix_a} * {{PIXEL_BITS{1'b0}}, pix_a};
         prod_bb_ff <= {{PIXEL_BITS{1'b0}}, pix_b} * {{PIXEL_BITS{1'b0}}, pix_b};
         prod_ab_ff <= {{PIXEL_BITS{1'b0}}, pix_a} * {{PIXEL_BITS{1'b0}}, pix_b};
      end
   end

   // running sums, wrapping at their widths; cleared once the finish is delivered
   always_comb begin
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      sum_aa_in = sum_aa_ff;
      sum_bb_in = sum_bb_ff;
      sum_ab_in = sum_ab_ff;
      if (clear) begin
         count_in  = '0;
         sum_a_in  = '0;
         sum_b_in  = '0;
         sum_aa_in = '0;
         sum_bb_in = '0;
         sum_ab_in = '0;
      end else if (stage_valid_ff) begin
         count_in  = count_ff + COUNT_BITS'(1);
         sum_a_in  = sum_a_ff + {{COUNT_BITS{1'b0}}, a_ff};
         sum_b_in  = sum_b_ff + {{COUNT_BITS{1'b0}}, b_ff};
         sum_aa_in = sum_aa_ff + {{COUNT_BITS{1'b0}}, prod_aa_ff};
         sum_bb_in = sum_bb_ff + {{COUNT_BITS{1'b0}}, prod_bb_ff};
         sum_ab_in = sum_ab_ff + {{COUNT_BITS{1'b0}}, prod_ab_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         sum_aa_ff <= '0;
         sum_bb_ff <= '0;
         sum_ab_ff <= '0;
      end else begin
         count_ff  <= count_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         sum_aa_ff <= sum_aa_in;
         sum_bb_ff <= sum_bb_in;
         sum_ab_ff <= sum_ab_in;
      end
   end

   assign stage_last = stage_last_ff;
   assign count      = count_ff;
   assign sum_a      = sum_a_ff;
   assign sum_b      = sum_b_ff;
   assign sum_aa     = sum_aa_ff;
   assign sum_bb     = sum_bb_ff;
   assign sum_ab     = sum_ab_ff;

endmodule

### rtl/core/ipncc_alu.sv
module ipncc_alu
   import ipncc_pkg::*;
#(
   parameter int WIDTH = wide_width(PIXEL_BITS_DEF, COUNT_BITS_DEF)
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   input  logic             sub,
   output logic [WIDTH-1:0] res,
   output logic             cout,
   output logic             zero
);

   logic [WIDTH:0] total;

   // add, or subtract as opa + ~opb + 1; carry out high means opa >= opb on subtract
   assign total = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{WIDTH{1'b0}}, sub};
   assign res   = total[WIDTH-1:0];
   assign cout  = total[WIDTH];
   assign zero  = (total[WIDTH-1:0] == '0);

endmodule

### rtl/core/ipncc_engine.sv
module ipncc_engine
   import ipncc_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  out_free,
   input  logic [COUNT_BITS-1:0]                 count,
   input  logic [PIXEL_BITS+COUNT_BITS-1:0]      sum_a,
   input  logic [PIXEL_BITS+COUNT_BITS-1:0]      sum_b,
   input  logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_aa,
   input  logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_bb,
   input  logic [2*PIXEL_BITS+COUNT_BITS-1:0]    sum_ab,
   output logic                                  busy,
   output logic                                  done,
   output ncc_result_type                        result
);

   localparam int S1W = PIXEL_BITS + COUNT_BITS;
   localparam int VW  = 2 * S1W;
   localparam int WW  = wide_width(PIXEL_BITS, COUNT_BITS);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_NSAA,
      ST_MUL,
      ST_SV_A,
      ST_SUB_A,
      ST_SV_B,
      ST_SUB_B,
      ST_SV_N,
      ST_SUB_N,
      ST_SUB_N2,
      ST_SV_P,
      ST_SV_R,
      ST_SR_TB,
      ST_SR_VA,
      ST_SR_CMP,
      ST_SR_UPD,
      ST_FIN
   } state_type;

   state_type       state_ff, state_in;
   state_type       ret_ff, ret_in;
   logic [WW-1:0]   acc_ff, acc_in;
   logic [WW-1:0]   mcand_ff, mcand_in;
   logic [VW-1:0]   mplier_ff, mplier_in;
   logic [WW-1:0]   x_ff, x_in;
   logic [VW-1:0]   va_ff, va_in;
   logic [VW-1:0]   vb_ff, vb_in;
   logic [VW-1:0]   mag_ff, mag_in;
   logic [WW-1:0]   p_ff, p_in;
   logic [WW-1:0]   r_ff, r_in;
   logic [WW-1:0]   t_ff, t_in;
   logic [WW-1:0]   b_ff, b_in;
   logic [WW-1:0]   a_ff, a_in;
   logic [QK_W-1:0] k_ff, k_in;
   logic [Q_W-1:0]  q_ff, q_in;
   logic            neg_ff, neg_in;
   logic            flat_ff, flat_in;

   logic [WW-1:0]   alu_a;
   logic [WW-1:0]   alu_b;
   logic            alu_sub;
   logic [WW-1:0]   alu_res;
   logic            alu_cout;
   logic            alu_zero;

   ipncc_alu #(
      .WIDTH (WW)
   ) u_alu (
      .opa  (alu_a),
      .opb  (alu_b),
      .sub  (alu_sub),
      .res  (alu_res),
      .cout (alu_cout),
      .zero (alu_zero)
   );

   // sequencer: shift-add multiplies, variance subtracts, then a bitwise root search
   // for the largest q with q*q*varA*varB <= 2^28*num*num, q in 0..16384
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      x_in      = x_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      mag_in    = mag_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      t_in      = t_ff;
      b_in      = b_ff;
      a_in      = a_ff;
      k_in      = k_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      flat_in   = flat_ff;
      alu_a     = acc_ff;
      alu_b     = mcand_ff;
      alu_sub   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               q_in     = '0;
               neg_in   = 1'b0;
               flat_in  = 1'b0;
               state_in = ST_LD_NSAA;
            end
         end
         ST_LD_NSAA: begin
            acc_in    = '0;
            mcand_in  = WW'(sum_aa);
            mplier_in = VW'(count);
            ret_in    = ST_SV_A;
            state_in  = ST_MUL;
         end
         // one multiplier bit a cycle, LSB first, ends once the rest is zero
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = alu_res;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (mplier_ff[VW-1:1] == '0) begin
               state_in = ret_ff;
            end
         end
         ST_SV_A: begin
            x_in      = acc_ff;
            acc_in    = '0;
            mcand_in  = WW'(sum_a);
            mplier_in = VW'(sum_a);
            ret_in    = ST_SUB_A;
            state_in  = ST_MUL;
         end
         ST_SUB_A: begin
            alu_a   = x_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            va_in   = alu_res[VW-1:0];
            if (!alu_cout || alu_zero) begin
               flat_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               acc_in    = '0;
               mcand_in  = WW'(sum_bb);
               mplier_in = VW'(count);
               ret_in    = ST_SV_B;
               state_in  = ST_MUL;
            end
         end
         ST_SV_B: begin
            x_in      = acc_ff;
            acc_in    = '0;
            mcand_in  = WW'(sum_b);
            mplier_in = VW'(sum_b);
            ret_in    = ST_SUB_B;
            state_in  = ST_MUL;
         end
         ST_SUB_B: begin
            alu_a   = x_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            vb_in   = alu_res[VW-1:0];
            if (!alu_cout || alu_zero) begin
               flat_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               acc_in    = '0;
               mcand_in  = WW'(sum_ab);
               mplier_in = VW'(count);
               ret_in    = ST_SV_N;
               state_in  = ST_MUL;
            end
         end
         ST_SV_N: begin
            x_in      = acc_ff;
            acc_in    = '0;
            mcand_in  = WW'(sum_a);
            mplier_in = VW'(sum_b);
            ret_in    = ST_SUB_N;
            state_in  = ST_MUL;
         end
         // numerator sign and magnitude; zero numerator gives zero correlation
         ST_SUB_N: begin
            alu_a   = x_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            if (alu_zero) begin
               state_in = ST_FIN;
            end else if (alu_cout) begin
               mag_in    = alu_res[VW-1:0];
               acc_in    = '0;
               mcand_in  = WW'(va_ff);
               mplier_in = vb_ff;
               ret_in    = ST_SV_P;
               state_in  = ST_MUL;
            end else begin
               neg_in   = 1'b1;
               state_in = ST_SUB_N2;
            end
         end
         ST_SUB_N2: begin
            alu_a     = acc_ff;
            alu_b     = x_ff;
            alu_sub   = 1'b1;
            mag_in    = alu_res[VW-1:0];
            acc_in    = '0;
            mcand_in  = WW'(va_ff);
            mplier_in = vb_ff;
            ret_in    = ST_SV_P;
            state_in  = ST_MUL;
         end
         ST_SV_P: begin
            p_in      = acc_ff;
            acc_in    = '0;
            mcand_in  = WW'(mag_ff);
            mplier_in = mag_ff;
            ret_in    = ST_SV_R;
            state_in  = ST_MUL;
         end
         // search setup: T = q^2*p, B = q*p*2^(k+1), A = p*4^k, top bit first
         ST_SV_R: begin
            r_in     = acc_ff << (2 * Q_FRAC);
            t_in     = '0;
            b_in     = '0;
            a_in     = p_ff << (2 * Q_FRAC);
            k_in     = QK_W'(Q_FRAC);
            state_in = ST_SR_TB;
         end
         ST_SR_TB: begin
            alu_a    = t_ff;
            alu_b    = b_ff;
            acc_in   = alu_res;
            state_in = ST_SR_VA;
         end
         ST_SR_VA: begin
            alu_a    = acc_ff;
            alu_b    = a_ff;
            acc_in   = alu_res;
            state_in = ST_SR_CMP;
         end
         // candidate square times p against the scaled numerator square
         ST_SR_CMP: begin
            alu_a   = r_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            if (alu_cout) begin
               t_in = acc_ff;
               q_in = q_ff | (Q_W'(1) << k_ff);
               if (k_ff == QK_W'(Q_FRAC)) begin
                  // full scale reached: saturate
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SR_UPD;
               end
            end else begin
               b_in = b_ff >> 1;
               a_in = a_ff >> 2;
               if (k_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  k_in     = k_ff - QK_W'(1);
                  state_in = ST_SR_TB;
               end
            end
         end
         ST_SR_UPD: begin
            alu_a = b_ff >> 1;
            alu_b = a_ff;
            b_in  = alu_res;
            a_in  = a_ff >> 2;
            if (k_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff - QK_W'(1);
               state_in = ST_SR_TB;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         k_ff     <= '0;
         q_ff     <= '0;
         neg_ff   <= 1'b0;
         flat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         k_ff     <= k_in;
         q_ff     <= q_in;
         neg_ff   <= neg_in;
         flat_ff  <= flat_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      x_ff      <= x_in;
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      mag_ff    <= mag_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      t_ff      <= t_in;
      b_ff      <= b_in;
      a_ff      <= a_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign done        = (state_ff == ST_FIN) && out_free;
   assign result.mag  = q_ff;
   assign result.neg  = neg_ff;
   assign result.flat = flat_ff;

endmodule

### rtl/core/image_pair_ncc_unit.sv
// image_pair_ncc_unit: pixel pairs accumulate at one beat per clock while req_ready is
// high; it drops while the last pair lands and during the finish. The last pair starts a
// serial finish on one shared wide adder: shift-add multiplies and a bitwise root search
// of up to 15 steps, which a flat image skips. No input beat is taken during the finish.
// Synchronous active-high reset clears the sums, the sequencer and the output beat, and
// sets the threshold to 16368.
`include "image_pair_ncc_unit_macros.svh"

module image_pair_ncc_unit
   import ipncc_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_FIELD_W-1:0] req_pixel_a,
   input  logic [PIX_FIELD_W-1:0] req_pixel_b,
   input  logic                   req_last_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [NCC_W-1:0]       rsp_ncc_q14,
   output logic                   rsp_above_threshold,
   output logic                   rsp_flat_image,
   input  logic                   csr_write_enable,
   input  logic [THR_W-1:0]       csr_write_data
);

   localparam int S1W = PIXEL_BITS + COUNT_BITS;
   localparam int S2W = 2 * PIXEL_BITS + COUNT_BITS;

   logic                  beat_in;
   logic                  stage_last;
   logic [COUNT_BITS-1:0] acc_count;
   logic [S1W-1:0]        acc_sum_a;
   logic [S1W-1:0]        acc_sum_b;
   logic [S2W-1:0]        acc_sum_aa;
   logic [S2W-1:0]        acc_sum_bb;
   logic [S2W-1:0]        acc_sum_ab;
   logic                  eng_busy;
   logic                  eng_done;
   logic                  out_free;
   ncc_result_type        eng_result;

   logic [THR_W-1:0]      thr_ff;
   logic                  rsp_valid_ff;
   logic [NCC_W-1:0]      rsp_ncc_ff;
   logic                  rsp_above_ff;
   logic                  rsp_flat_ff;
   logic [NCC_W-1:0]      ncc_in;
   logic                  above_in;

   // input side: stalled while the last pair lands and during the finish
   assign req_ready = !stage_last && !eng_busy;
   assign beat_in   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   ipncc_accum #(
      .PIXEL_BITS (PIXEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .beat_in    (beat_in),
      .pix_a      (req_pixel_a[PIXEL_BITS-1:0]),
      .pix_b      (req_pixel_b[PIXEL_BITS-1:0]),
      .last_in    (req_last_pixel),
      .clear      (eng_done),
      .stage_last (stage_last),
      .count      (acc_count),
      .sum_a      (acc_sum_a),
      .sum_b      (acc_sum_b),
      .sum_aa     (acc_sum_aa),
      .sum_bb     (acc_sum_bb),
      .sum_ab     (acc_sum_ab)
   );

   ipncc_engine #(
      .PIXEL_BITS (PIXEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (stage_last),
      .out_free (out_free),
      .count    (acc_count),
      .sum_a    (acc_sum_a),
      .sum_b    (acc_sum_b),
      .sum_aa   (acc_sum_aa),
      .sum_bb   (acc_sum_bb),
      .sum_ab   (acc_sum_ab),
      .busy     (eng_busy),
      .done     (eng_done),
      .result   (eng_result)
   );

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   // signed result and strict threshold compare
   always_comb begin
      ncc_in   = eng_result.neg ? (NCC_W'(0) - NCC_W'(eng_result.mag))
                                : NCC_W'(eng_result.mag);
      above_in = $signed({ncc_in[NCC_W-1], ncc_in}) > $signed({2'b00, thr_ff});
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done) begin
         rsp_ncc_ff   <= ncc_in;
         rsp_above_ff <= above_in;
         rsp_flat_ff  <= eng_result.flat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ncc_q14         = rsp_ncc_ff;
   assign rsp_above_threshold = rsp_above_ff;
   assign rsp_flat_image      = rsp_flat_ff;

   `IPNCC_ASSERT_NOW(a_flat_is_zero, clock, reset, rsp_valid && rsp_flat_image, (rsp_ncc_q14 == '0) && !rsp_above_threshold, "flat result with nonzero correlation or flag")
   `IPNCC_ASSERT_NOW(a_ncc_range, clock, reset, rsp_valid, ($signed(rsp_ncc_q14) <= Q_ONE_S) && ($signed(rsp_ncc_q14) >= -Q_ONE_S), "correlation beyond full scale")
   `IPNCC_ASSERT_NEXT(a_clear_after_done, clock, reset, eng_done, (acc_count == '0) && (acc_sum_ab == '0), "sums not cleared after finish")
   `IPNCC_ASSERT_NOW(a_no_beat_in_finish, clock, reset, eng_busy || stage_last, !req_ready, "input taken during finish")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import ipncc_pkg::*;

   localparam int PIX_W         = PIXEL_BITS_DEF;
   localparam int CNT_W         = COUNT_BITS_DEF;
   localparam int S1_W          = PIX_W + CNT_W;
   localparam int S2_W          = 2 * PIX_W + CNT_W;
   localparam int Q_MAX         = 1 << Q_FRAC;
   localparam int SETTLE_CYCLES = 450;
   localparam int HOLD_CYCLES   = 700;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 168;
   localparam int MAX_REPORTS   = 10;

   typedef logic [255:0] big_type;

   typedef struct {
      logic [PIX_FIELD_W-1:0] a;
      logic [PIX_FIELD_W-1:0] b;
      logic                   last;
   } pixel_pair_type;

   typedef struct {
      logic [NCC_W-1:0] ncc;
      logic             above;
      logic             flat;
   } ncc_beat_type;

   // pixel content of one random image
   typedef enum int {
      STY_INDEP, STY_BYTE, STY_CORR, STY_ANTI, STY_SAME, STY_FLAT_A, STY_FLAT_B, STY_LINEAR
   } image_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIX_FIELD_W-1:0] req_pixel_a = '0;
   logic [PIX_FIELD_W-1:0] req_pixel_b = '0;
   logic                   req_last_pixel = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [NCC_W-1:0]       rsp_ncc_q14;
   logic                   rsp_above_threshold;
   logic                   rsp_flat_image;
   logic                   csr_write_enable = 1'b0;
   logic [THR_W-1:0]       csr_write_data = '0;

   image_pair_ncc_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_a         (req_pixel_a),
      .req_pixel_b         (req_pixel_b),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ncc_q14         (rsp_ncc_q14),
      .rsp_above_threshold (rsp_above_threshold),
      .rsp_flat_image      (rsp_flat_image),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // stimulus and scoreboard storage
   pixel_pair_type pending_pairs[$];
   ncc_beat_type   ncc_expected[$];
   int             mismatch_count = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   logic           hold_go = 1'b0;
   logic           hold_used = 1'b0;
   int unsigned    hold_left = 0;

   // shadow of the threshold register and of the image accumulators
   logic [THR_W-1:0] match_thr = THR_RESET;
   logic [CNT_W-1:0] img_count = '0;
   logic [S1_W-1:0]  img_sum_a = '0;
   logic [S1_W-1:0]  img_sum_b = '0;
   logic [S2_W-1:0]  img_sum_aa = '0;
   logic [S2_W-1:0]  img_sum_bb = '0;
   logic [S2_W-1:0]  img_sum_ab = '0;

   // Fold one accepted pair into the sums; on the last pair predict the correlation beat.
   task automatic fold_pixel_pair(input logic [PIX_FIELD_W-1:0] pa,
                                  input logic [PIX_FIELD_W-1:0] pb, input logic last);
      big_type a, b, n, x, y, var_a, var_b, mag, prod, rhs, lhs;
      logic flat, neg;
      int unsigned lo, hi, mid;
      logic signed [NCC_W:0] ncc;
      ncc_beat_type res;
      a = big_type'(pa[PIX_W-1:0]);
      b = big_type'(pb[PIX_W-1:0]);
      img_count  = img_count + 1'b1;
      img_sum_a  = S1_W'(big_type'(img_sum_a) + a);
      img_sum_b  = S1_W'(big_type'(img_sum_b) + b);
      img_sum_aa = S2_W'(big_type'(img_sum_aa) + a * a);
      img_sum_bb = S2_W'(big_type'(img_sum_bb) + b * b);
      img_sum_ab = S2_W'(big_type'(img_sum_ab) + a * b);
      if (last) begin
         n = big_type'(img_count);
         var_a = '0;
         var_b = '0;
         x = n * big_type'(img_sum_aa);
         y = big_type'(img_sum_a) * big_type'(img_sum_a);
         flat = (img_count == 0) || (x <= y);
         if (!flat) var_a = x - y;
         x = n * big_type'(img_sum_bb);
         y = big_type'(img_sum_b) * big_type'(img_sum_b);
         flat = flat || (x <= y);
         if (!flat) var_b = x - y;
         neg = 1'b0;
         lo = 0;
         if (!flat) begin
            x = n * big_type'(img_sum_ab);
            y = big_type'(img_sum_a) * big_type'(img_sum_b);
            neg = x < y;
            mag = neg ? y - x : x - y;
            // largest q with q*q*varA*varB <= 2^28*num*num
            if (mag != 0) begin
               prod = var_a * var_b;
               rhs = (mag * mag) << (2 * Q_FRAC);
               hi = Q_MAX;
               while (lo < hi) begin
                  mid = (lo + hi + 1) / 2;
                  lhs = big_type'(mid) * big_type'(mid) * prod;
                  if (lhs <= rhs) lo = mid;
                  else hi = mid - 1;
               end
            end
         end
         ncc = (NCC_W + 1)'(lo);
         if (neg) ncc = -ncc;
         res.ncc   = ncc[NCC_W-1:0];
         res.above = ncc > $signed({2'b00, match_thr});
         res.flat  = flat;
         ncc_expected = {ncc_expected, res};
         img_count  = '0;
         img_sum_a  = '0;
         img_sum_b  = '0;
         img_sum_aa = '0;
         img_sum_bb = '0;
         img_sum_ab = '0;
      end
   endtask

   // Pixel driver: predicts on each accepted beat, then offers the next pair.
   pixel_pair_type next_pair;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) fold_pixel_pair(req_pixel_a, req_pixel_b, req_last_pixel);
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_pairs.pop_front();
               req_valid      <= 1'b1;
               req_pixel_a    <= next_pair.a;
               req_pixel_b    <= next_pair.b;
               req_last_pixel <= next_pair.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result ready: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Result monitor: compare each beat against the oldest prediction.
   ncc_beat_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ncc_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: ncc=%0d above=%0b flat=%0b",
                        $signed(rsp_ncc_q14), rsp_above_threshold, rsp_flat_image);
         end else begin
            want = ncc_expected.pop_front();
            if (rsp_ncc_q14 !== want.ncc || rsp_above_threshold !== want.above ||
                rsp_flat_image !== want.flat) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("result mismatch: expected ncc=%0d above=%0b flat=%0b",
                           $signed(want.ncc), want.above, want.flat);
                  $display("   got ncc=%0d above=%0b flat=%0b",
                           $signed(rsp_ncc_q14), rsp_above_threshold, rsp_flat_image);
               end
            end
         end
      end
   end

   task automatic queue_pair(input int unsigned a, input int unsigned b, input logic last);
      pixel_pair_type p;
      p.a = a[PIX_FIELD_W-1:0];
      p.b = b[PIX_FIELD_W-1:0];
      p.last = last;
      pending_pairs = {pending_pairs, p};
   endtask

   function automatic int unsigned clamp_pixel(input int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // One random image: mostly small, sometimes medium, rarely long; cut at max_len pairs.
   task automatic queue_image(input int unsigned max_len, output int unsigned len);
      image_style_type style;
      int unsigned     pick, k, a, b, base_a, base_b;
      int              spread, noise;
      pick = $urandom_range(99);
      if (pick < 85) len = $urandom_range(24, 1);
      else if (pick < 98) len = $urandom_range(100, 25);
      else len = $urandom_range(500, 200);
      if (len > max_len) len = max_len;
      style  = image_style_type'($urandom_range(STY_LINEAR));
      base_a = $urandom_range(65535);
      base_b = $urandom_range(65535);
      spread = $urandom_range(3000, 1);
      for (k = 0; k < len; k++) begin
         a = $urandom_range(65535);
         b = $urandom_range(65535);
         noise = int'($urandom_range(2 * spread)) - spread;
         case (style)
            STY_BYTE: begin
               a = a & 8'hff;
               b = b & 8'hff;
            end
            STY_CORR:   b = clamp_pixel(int'(a) + noise);
            STY_ANTI:   b = clamp_pixel(65535 - int'(a) + noise);
            STY_SAME:   b = a;
            STY_FLAT_A: a = base_a;
            STY_FLAT_B: b = base_b;
            STY_LINEAR: begin
               a = a >> 1;
               b = 2 * a + 1;
            end
            default: ;
         endcase
         queue_pair(a, b, k == len - 1);
      end
   endtask

   // Idle means no pair pending or offered and no result outstanding.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_valid || ncc_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      match_thr = v;
   endtask

   int unsigned phase_thr[PHASES] = '{0, 32767, 16384, 16368, 8192, 1, 12000, 0};
   int unsigned send_pct[4] = '{0, 53, 0, 25};
   int unsigned recv_pct[4] = '{0, 0, 53, 25};

   initial begin
      int unsigned p, queued, len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed images at the reset threshold
      queue_pair(65535, 65535, 1'b1);               // single pair: flat
      queue_pair(0, 0, 1'b0);                       // full-scale identical: +1
      queue_pair(65535, 65535, 1'b1);
      queue_pair(0, 65535, 1'b0);                   // full-scale inverted: -1
      queue_pair(65535, 0, 1'b1);
      queue_pair(7, 1, 1'b0);                       // constant first image
      queue_pair(7, 2, 1'b0);
      queue_pair(7, 3, 1'b1);
      queue_pair(1, 5, 1'b0);                       // constant second image
      queue_pair(2, 5, 1'b0);
      queue_pair(3, 5, 1'b1);
      queue_pair(1, 2, 1'b0);                       // partial correlation
      queue_pair(2, 1, 1'b0);
      queue_pair(3, 4, 1'b0);
      queue_pair(4, 3, 1'b1);
      queue_pair(16'h5555, 16'haaaa, 1'b0);
      queue_pair(16'haaaa, 16'h5555, 1'b0);
      queue_pair(16'h1234, 16'h8000, 1'b1);

      // random phases over thresholds and idle patterns
      phase_thr[6] = $urandom_range(32767);
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         write_threshold(THR_W'(phase_thr[p]));
         @(negedge clock);
         send_idle_pct  = send_pct[p % 4];
         recv_stall_pct = recv_pct[p % 4];
         if (p == 0) hold_go = 1'b1;
         queued = 0;
         while (queued < PHASE_BEATS) begin
            queue_image(PHASE_BEATS - queued, len);
            queued += len;
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(64'd3_000_000 * 12);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### image_pair_ncc_unit.f
+incdir+rtl/core
rtl/core/ipncc_pkg.sv
rtl/core/ipncc_accum.sv
rtl/core/ipncc_alu.sv
rtl/core/ipncc_engine.sv
rtl/core/image_pair_ncc_unit.sv
tb/tb.sv
